[design/jsud_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsud_pkg
// Types, codes and helper functions shared by the JSON string unescape
// decoder: parse modes, result kinds, result records and UTF-8 constants.
// ----------------------------------------------------------------------------
package jsud_pkg;

	localparam int RES_MAX = 4;
	localparam int CNT_W   = $clog2(RES_MAX + 1);

	typedef enum logic [3:0] {
		MODE_WAIT = 4'b0001,
		MODE_STR  = 4'b0010,
		MODE_ESC  = 4'b0100,
		MODE_HEX  = 4'b1000
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_U = 8'h75;

	localparam logic [15:0] UTF8_LIMIT1 = 16'h0080;
	localparam logic [15:0] UTF8_LIMIT2 = 16'h0800;
	localparam logic [7:0]  UTF8_CONT   = 8'h80;
	localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0]  UTF8_MASK   = 8'h3F;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      result_kind;
		logic       last_of_run;
	} result_t;

	// All results caused by one input request.
	typedef struct packed {
		logic [CNT_W-1:0]          count;
		result_t [RES_MAX-1:0]     res;
	} group_t;

	function automatic result_t mk_result(input logic [7:0] b, input kind_t k);
		result_t r;
		r.out_byte    = b;
		r.result_kind = k;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_value(input logic [7:0] h);
		logic [4:0] v;
		v = 5'd0;
		if (h >= 8'h30 && h <= 8'h39) begin
			v = {1'b1, 4'(h - 8'h30)};
		end else if (h >= 8'h61 && h <= 8'h66) begin
			v = {1'b1, 4'(h - 8'h57)};
		end else if (h >= 8'h41 && h <= 8'h46) begin
			v = {1'b1, 4'(h - 8'h37)};
		end
		return v;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] e);
		logic [7:0] r;
		unique case (e)
			8'h6E: r = 8'h0A;
			8'h72: r = 8'h0D;
			8'h74: r = 8'h09;
			8'h62: r = 8'h08;
			8'h66: r = 8'h0C;
			default: r = e;
		endcase
		return r;
	endfunction

endpackage

[design/jsud_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsud_if
// Valid/ready channels of the decoder: source text bytes in, decoded results
// out.
// ----------------------------------------------------------------------------
interface jsud_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsud_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] result_kind;
	logic       last_of_run;

	modport source (output valid, output out_byte, output result_kind,
		output last_of_run, input ready);
	modport sink (input valid, input out_byte, input result_kind,
		input last_of_run, output ready);
endinterface

[design/jsud_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsud_decoder
// Parse state and the single-pass decode of one source byte into a group of
// up to four results.
// ----------------------------------------------------------------------------
module jsud_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        in_byte,
	input  logic              end_of_input,
	input  logic              take,
	output jsud_pkg::group_t  grp
);

	jsud_pkg::mode_t mode_q, mode_d;
	logic [1:0]      hex_q, hex_d;
	logic [15:0]     cp_q, cp_d;
	logic [15:0]     cp_new;
	logic [4:0]      hv;
	logic [2:0]      n;
	logic [2:0]      n_m1;
	logic            finished;
	logic            is_space;

	always_comb begin
		grp      = '0;
		n        = 3'd0;
		finished = 1'b0;
		mode_d   = mode_q;
		hex_d    = hex_q;
		cp_d     = cp_q;
		hv       = jsud_pkg::hex_value(in_byte);
		cp_new   = {cp_q[11:0], hv[3:0]};
		is_space = (in_byte == jsud_pkg::CH_SPACE) || (in_byte == jsud_pkg::CH_TAB) ||
			(in_byte == jsud_pkg::CH_LF) || (in_byte == jsud_pkg::CH_CR);

		unique case (mode_q)
			jsud_pkg::MODE_WAIT: begin
				if (in_byte == jsud_pkg::CH_QUOTE) begin
					mode_d = jsud_pkg::MODE_STR;
				end else if (!is_space) begin
					grp.res[0] = jsud_pkg::mk_result(8'd0, jsud_pkg::KIND_ERROR);
					n = 3'd1;
					finished = 1'b1;
				end
			end
			jsud_pkg::MODE_STR: begin
				if (in_byte == jsud_pkg::CH_QUOTE) begin
					grp.res[0] = jsud_pkg::mk_result(8'd0, jsud_pkg::KIND_CLOSE);
					n = 3'd1;
					finished = 1'b1;
				end else if (in_byte == jsud_pkg::CH_BSLASH) begin
					mode_d = jsud_pkg::MODE_ESC;
				end else begin
					grp.res[0] = jsud_pkg::mk_result(in_byte, jsud_pkg::KIND_DATA);
					n = 3'd1;
				end
			end
			jsud_pkg::MODE_ESC: begin
				if (in_byte == jsud_pkg::CH_U) begin
					mode_d = jsud_pkg::MODE_HEX;
					hex_d  = 2'd0;
					cp_d   = 16'd0;
				end else begin
					grp.res[0] = jsud_pkg::mk_result(jsud_pkg::unescape(in_byte),
						jsud_pkg::KIND_DATA);
					n = 3'd1;
					mode_d = jsud_pkg::MODE_STR;
				end
			end
			jsud_pkg::MODE_HEX: begin
				if (!hv[4]) begin
					grp.res[0] = jsud_pkg::mk_result(8'd0, jsud_pkg::KIND_ERROR);
					n = 3'd1;
					finished = 1'b1;
				end else if (hex_q == 2'd3) begin
					// Fourth digit: encode the code point as UTF-8.
					if (cp_new < jsud_pkg::UTF8_LIMIT1) begin
						grp.res[0] = jsud_pkg::mk_result(cp_new[7:0], jsud_pkg::KIND_DATA);
						n = 3'd1;
					end else if (cp_new < jsud_pkg::UTF8_LIMIT2) begin
						grp.res[0] = jsud_pkg::mk_result(
							jsud_pkg::UTF8_LEAD2 | {3'd0, cp_new[10:6]}, jsud_pkg::KIND_DATA);
						grp.res[1] = jsud_pkg::mk_result(
							jsud_pkg::UTF8_CONT | (cp_new[7:0] & jsud_pkg::UTF8_MASK),
							jsud_pkg::KIND_DATA);
						n = 3'd2;
					end else begin
						grp.res[0] = jsud_pkg::mk_result(
							jsud_pkg::UTF8_LEAD3 | {4'd0, cp_new[15:12]}, jsud_pkg::KIND_DATA);
						grp.res[1] = jsud_pkg::mk_result(
							jsud_pkg::UTF8_CONT | (cp_new[13:6] & jsud_pkg::UTF8_MASK),
							jsud_pkg::KIND_DATA);
						grp.res[2] = jsud_pkg::mk_result(
							jsud_pkg::UTF8_CONT | (cp_new[7:0] & jsud_pkg::UTF8_MASK),
							jsud_pkg::KIND_DATA);
						n = 3'd3;
					end
					mode_d = jsud_pkg::MODE_STR;
					hex_d  = 2'd0;
					cp_d   = 16'd0;
				end else begin
					cp_d  = cp_new;
					hex_d = hex_q + 2'd1;
				end
			end
			default: begin
				mode_d = jsud_pkg::MODE_WAIT;
			end
		endcase

		// The source ended without a closed string.
		if (end_of_input && !finished) begin
			grp.res[n[1:0]] = jsud_pkg::mk_result(8'd0, jsud_pkg::KIND_ERROR);
			n = n + 3'd1;
			finished = 1'b1;
		end

		if (finished) begin
			mode_d = jsud_pkg::MODE_WAIT;
			hex_d  = 2'd0;
			cp_d   = 16'd0;
		end

		n_m1 = n - 3'd1;
		if (n != 3'd0) begin
			grp.res[n_m1[1:0]].last_of_run = 1'b1;
		end
		grp.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsud_pkg::MODE_WAIT;
			hex_q  <= 2'd0;
			cp_q   <= 16'd0;
		end else if (take) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
			cp_q   <= cp_d;
		end
	end

endmodule

[design/jsud_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsud_serializer
// Result register holding the group of one input request; hands its entries
// out one per cycle while the receiver is ready, and shifts the rest down.
// ----------------------------------------------------------------------------
module jsud_serializer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  jsud_pkg::group_t               grp,
	output logic                           can_load,
	output logic [jsud_pkg::CNT_W-1:0]     count,
	jsud_out_if.source                     decoded
);

	logic [jsud_pkg::CNT_W-1:0]               cnt_s2;
	jsud_pkg::result_t [jsud_pkg::RES_MAX-1:0] res_s2;
	logic                                     pop;

	assign pop      = decoded.valid && decoded.ready;
	// A new group may enter once the current one is empty or its last entry is being taken.
	assign can_load = (cnt_s2 == '0) ||
		((cnt_s2 == jsud_pkg::CNT_W'(1)) && decoded.ready);
	assign count    = cnt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2 <= '0;
		end else if (load) begin
			cnt_s2 <= grp.count;
		end else if (pop) begin
			cnt_s2 <= cnt_s2 - jsud_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= grp.res;
		end else if (pop) begin
			for (int i = 0; i < jsud_pkg::RES_MAX - 1; i++) begin
				res_s2[i] <= res_s2[i+1];
			end
		end
	end

	assign decoded.valid       = (cnt_s2 != '0);
	assign decoded.out_byte    = res_s2[0].out_byte;
	assign decoded.result_kind = res_s2[0].result_kind;
	assign decoded.last_of_run = res_s2[0].last_of_run;

endmodule

[design/json_string_unescape_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_decoder
// Unescapes a quoted JSON string byte by byte, with UTF-8 output for \u.
//
//   channel   dir  payload                                  request
//   text      in   in_byte[7:0], end_of_input               one source byte
//   decoded   out  out_byte[7:0], result_kind[1:0],         one result
//                  last_of_run
//
// A source byte is decoded in the cycle it is accepted; its results sit in
// the result register from the next cycle on and leave one per cycle while the receiver is ready.
// A byte that yields at most one result lets the next byte in every cycle while
// the receiver is ready; a byte that yields more results holds the input until its last
// result is being taken, since the result register has a single output port.
// Reset clears the parse state and empties the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	jsud_in_if.sink     text,
	jsud_out_if.source  decoded
);

	jsud_pkg::group_t            grp;
	logic                        take;
	logic                        can_load;
	logic [jsud_pkg::CNT_W-1:0]  count;

	assign text.ready = can_load;
	assign take       = text.valid && can_load;

	jsud_decoder u_decoder (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (text.in_byte),
		.end_of_input (text.end_of_input),
		.take         (take),
		.grp          (grp)
	);

	jsud_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take),
		.grp      (grp),
		.can_load (can_load),
		.count    (count),
		.decoded  (decoded)
	);

	// Close and error always end the run of their source byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && (decoded.result_kind != jsud_pkg::KIND_DATA)
		|-> decoded.last_of_run)
		else $error("close or error result not marked last of run");

	// Entries of a run that remain after a taken result stay queued.
	assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && decoded.ready && !decoded.last_of_run |=> decoded.valid)
		else $error("run broken before its last result");

	// Only a result marked last may be the final entry of the register.
	assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && (count == jsud_pkg::CNT_W'(1)) |-> decoded.last_of_run)
		else $error("final queued result not marked last of run");

	assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid |-> (decoded.result_kind != 2'd3))
		else $error("undefined result kind");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON string unescape decoder. A queue of source
// bytes (a short directed string set, then random quoted strings with escapes,
// \u code points, truncations and noise) feeds a valid/ready driver. A local
// decoder model predicts each result, and the monitor compares every decoded
// result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

	localparam int N_ITEMS     = 470;
	localparam int HOLD_CYCLES = 150;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} src_byte_t;

	logic clk = 1'b0;
	logic arst_n;

	jsud_in_if  text_if ();
	jsud_out_if dec_if ();

	json_string_unescape_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_if.sink),
		.decoded (dec_if.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	src_byte_t           pending_q[$];
	jsud_pkg::result_t   expected_q[$];

	// Decoder state as seen by the bench.
	jsud_pkg::mode_t dec_mode  = jsud_pkg::MODE_WAIT;
	logic [1:0]      dig_cnt   = 2'd0;
	logic [15:0]     cp_acc    = 16'd0;

	int n_items    = 0;
	int sent_cnt   = 0;
	int result_cnt = 0;
	int close_cnt  = 0;
	int err_cnt    = 0;
	int fail_cnt   = 0;
	int hold_at    = 0;
	int hold_left  = 0;
	bit hold_done  = 1'b0;

	src_byte_t         nxt;
	jsud_pkg::result_t want;

	logic [7:0] esc_chars[8] = '{8'h22, 8'h5C, 8'h2F, 8'h6E, 8'h72, 8'h74, 8'h62, 8'h66};
	logic [7:0] ws_chars[4]  = '{jsud_pkg::CH_SPACE, jsud_pkg::CH_TAB, jsud_pkg::CH_LF,
		jsud_pkg::CH_CR};
	// Bytes just outside the hex digit ranges.
	logic [7:0] bad_hex[6]   = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

	// Idle percentage of one side for the current phase of the run.
	function automatic int idle_pct(input bit rx);
		if (sent_cnt < n_items / 3) begin
			return rx ? 62 : 9;
		end else if (sent_cnt < (2 * n_items) / 3) begin
			return rx ? 9 : 62;
		end
		return 0;
	endfunction

	task automatic decode_byte(input logic [7:0] b, input logic eoi);
		jsud_pkg::result_t grp[$];
		logic        done;
		logic        hex_ok;
		logic [3:0]  nib;
		logic [15:0] cp;
		logic [7:0]  ch;
		done   = 1'b0;
		hex_ok = 1'b1;
		nib    = 4'd0;
		case (dec_mode)
			jsud_pkg::MODE_WAIT: begin
				if (b == jsud_pkg::CH_QUOTE) begin
					dec_mode = jsud_pkg::MODE_STR;
				end else if (!(b == jsud_pkg::CH_SPACE || b == jsud_pkg::CH_TAB ||
					b == jsud_pkg::CH_LF || b == jsud_pkg::CH_CR)) begin
					grp.push_back('{8'h00, jsud_pkg::KIND_ERROR, 1'b0});
					done = 1'b1;
				end
			end
			jsud_pkg::MODE_STR: begin
				if (b == jsud_pkg::CH_QUOTE) begin
					grp.push_back('{8'h00, jsud_pkg::KIND_CLOSE, 1'b0});
					done = 1'b1;
				end else if (b == jsud_pkg::CH_BSLASH) begin
					dec_mode = jsud_pkg::MODE_ESC;
				end else begin
					grp.push_back('{b, jsud_pkg::KIND_DATA, 1'b0});
				end
			end
			jsud_pkg::MODE_ESC: begin
				if (b == jsud_pkg::CH_U) begin
					dec_mode = jsud_pkg::MODE_HEX;
					dig_cnt  = 2'd0;
					cp_acc   = 16'd0;
				end else begin
					case (b)
						8'h6E: ch = 8'h0A;
						8'h72: ch = 8'h0D;
						8'h74: ch = 8'h09;
						8'h62: ch = 8'h08;
						8'h66: ch = 8'h0C;
						default: ch = b;
					endcase
					grp.push_back('{ch, jsud_pkg::KIND_DATA, 1'b0});
					dec_mode = jsud_pkg::MODE_STR;
				end
			end
			default: begin
				if (b >= 8'h30 && b <= 8'h39) begin
					nib = 4'(b - 8'h30);
				end else if (b >= 8'h61 && b <= 8'h66) begin
					nib = 4'(b - 8'h61 + 8'd10);
				end else if (b >= 8'h41 && b <= 8'h46) begin
					nib = 4'(b - 8'h41 + 8'd10);
				end else begin
					hex_ok = 1'b0;
				end
				if (!hex_ok) begin
					grp.push_back('{8'h00, jsud_pkg::KIND_ERROR, 1'b0});
					done = 1'b1;
				end else begin
					cp = {cp_acc[11:0], nib};
					cp_acc = cp;
					if (dig_cnt == 2'd3) begin
						if (cp < jsud_pkg::UTF8_LIMIT1) begin
							grp.push_back('{cp[7:0], jsud_pkg::KIND_DATA, 1'b0});
						end else if (cp < jsud_pkg::UTF8_LIMIT2) begin
							grp.push_back('{jsud_pkg::UTF8_LEAD2 | 8'(cp[10:6]),
								jsud_pkg::KIND_DATA, 1'b0});
							grp.push_back('{jsud_pkg::UTF8_CONT | 8'(cp[5:0]),
								jsud_pkg::KIND_DATA, 1'b0});
						end else begin
							// Surrogates are not paired, so they land here as well.
							grp.push_back('{jsud_pkg::UTF8_LEAD3 | 8'(cp[15:12]),
								jsud_pkg::KIND_DATA, 1'b0});
							grp.push_back('{jsud_pkg::UTF8_CONT | 8'(cp[11:6]),
								jsud_pkg::KIND_DATA, 1'b0});
							grp.push_back('{jsud_pkg::UTF8_CONT | 8'(cp[5:0]),
								jsud_pkg::KIND_DATA, 1'b0});
						end
						dec_mode = jsud_pkg::MODE_STR;
						dig_cnt  = 2'd0;
						cp_acc   = 16'd0;
					end else begin
						dig_cnt = dig_cnt + 2'd1;
					end
				end
			end
		endcase
		// A source that stops before the string is closed is an error.
		if (eoi && !done) begin
			grp.push_back('{8'h00, jsud_pkg::KIND_ERROR, 1'b0});
			done = 1'b1;
		end
		if (done) begin
			dec_mode = jsud_pkg::MODE_WAIT;
			dig_cnt  = 2'd0;
			cp_acc   = 16'd0;
		end
		if (grp.size() != 0) begin
			grp[grp.size() - 1].last_of_run = 1'b1;
		end
		foreach (grp[i]) begin
			expected_q.push_back(grp[i]);
		end
	endtask

	// Driver: offers the pending source bytes and predicts each accepted request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_if.valid && text_if.ready) begin
				decode_byte(text_if.in_byte, text_if.end_of_input);
				sent_cnt++;
			end
			if (!text_if.valid || text_if.ready) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
					nxt = pending_q.pop_front();
					text_if.valid        <= 1'b1;
					text_if.in_byte      <= nxt.b;
					text_if.end_of_input <= nxt.eoi;
				end else begin
					text_if.valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver stall late in the run, while the sender keeps offering.
	always @(posedge clk) begin
		if (arst_n && !hold_done && n_items != 0 && sent_cnt >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each accepted result against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (dec_if.valid && dec_if.ready) begin
				result_cnt++;
				if (dec_if.result_kind == jsud_pkg::KIND_CLOSE) begin
					close_cnt++;
				end
				if (dec_if.result_kind == jsud_pkg::KIND_ERROR) begin
					err_cnt++;
				end
				if (expected_q.size() == 0) begin
					$error("unexpected result: out_byte %h result_kind %0d last_of_run %0d",
						dec_if.out_byte, dec_if.result_kind, dec_if.last_of_run);
					fail_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (dec_if.out_byte !== want.out_byte) begin
						$error("out_byte: expected %h, actual %h", want.out_byte, dec_if.out_byte);
						fail_cnt++;
					end
					if (dec_if.result_kind !== want.result_kind) begin
						$error("result_kind: expected %0d, actual %0d", want.result_kind,
							dec_if.result_kind);
						fail_cnt++;
					end
					if (dec_if.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, actual %0d", want.last_of_run,
							dec_if.last_of_run);
						fail_cnt++;
					end
				end
			end
			dec_if.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_pct(1'b1));
		end
	end

	initial begin
		logic [7:0]  directed[];
		logic [7:0]  str_q[$];
		logic [7:0]  c;
		logic [15:0] cp;
		logic [3:0]  nib;
		int          sel;
		int          cut;
		bit          eoi_on_cut;

		arst_n               = 1'b0;
		text_if.valid        = 1'b0;
		text_if.in_byte      = 8'h00;
		text_if.end_of_input = 1'b0;
		dec_if.ready         = 1'b0;

		// Whitespace then a stray byte before any quote, a string with byte extremes,
		// a simple and an unknown escape, a two-byte code point in mixed case, then
		// a lone surrogate and a bad hex digit.
		directed = '{jsud_pkg::CH_CR, 8'h78,
			jsud_pkg::CH_QUOTE, 8'h00, 8'hFF, jsud_pkg::CH_BSLASH, 8'h6E,
			jsud_pkg::CH_BSLASH, 8'h71,
			jsud_pkg::CH_BSLASH, jsud_pkg::CH_U, 8'h30, 8'h37, 8'h46, 8'h66,
			jsud_pkg::CH_QUOTE,
			jsud_pkg::CH_QUOTE, jsud_pkg::CH_BSLASH, jsud_pkg::CH_U, 8'h44, 8'h38, 8'h30,
			8'h30, jsud_pkg::CH_BSLASH, jsud_pkg::CH_U, 8'h31, 8'h67};
		foreach (directed[i]) begin
			pending_q.push_back('{directed[i], 1'b0});
		end

		while (pending_q.size() < N_ITEMS) begin
			if ($urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 4)) begin
					pending_q.push_back('{8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0});
				end
			end else begin
				str_q.delete();
				repeat ($urandom_range(0, 2)) begin
					str_q.push_back(ws_chars[$urandom_range(0, 3)]);
				end
				str_q.push_back(jsud_pkg::CH_QUOTE);
				repeat ($urandom_range(0, 8)) begin
					sel = $urandom_range(0, 99);
					if (sel < 45) begin
						do begin
							c = 8'($urandom_range(0, 255));
						end while (c == jsud_pkg::CH_QUOTE || c == jsud_pkg::CH_BSLASH);
						str_q.push_back(c);
					end else if (sel < 65) begin
						str_q.push_back(jsud_pkg::CH_BSLASH);
						str_q.push_back(esc_chars[$urandom_range(0, 7)]);
					end else if (sel < 72) begin
						do begin
							c = 8'($urandom_range(0, 255));
						end while (c == jsud_pkg::CH_U);
						str_q.push_back(jsud_pkg::CH_BSLASH);
						str_q.push_back(c);
					end else begin
						case ($urandom_range(0, 2))
							0: cp = 16'($urandom_range(0, 16'h007F));
							1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
							default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
						endcase
						str_q.push_back(jsud_pkg::CH_BSLASH);
						str_q.push_back(jsud_pkg::CH_U);
						for (int k = 3; k >= 0; k--) begin
							nib = cp[k * 4 +: 4];
							if (nib < 4'd10) begin
								c = 8'h30 + 8'(nib);
							end else begin
								c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
							end
							str_q.push_back(c);
						end
						if (sel >= 96) begin
							str_q[str_q.size() - 1 - $urandom_range(0, 3)] = bad_hex[$urandom_range(0, 5)];
						end
					end
				end
				str_q.push_back(jsud_pkg::CH_QUOTE);
				cut        = str_q.size() - 1;
				eoi_on_cut = 1'b0;
				sel        = $urandom_range(0, 99);
				if (sel < 15) begin
					cut        = $urandom_range(0, str_q.size() - 1);
					eoi_on_cut = 1'b1;
				end else if (sel < 35) begin
					eoi_on_cut = 1'b1;
				end
				for (int k = 0; k <= cut; k++) begin
					pending_q.push_back('{str_q[k], (k == cut) && eoi_on_cut});
				end
			end
		end
		n_items = pending_q.size();
		hold_at = (3 * n_items) / 4;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || text_if.valid) begin
			@(posedge clk);
		end
		while (expected_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Fed %0d source bytes through whitespace, escapes, \\u code points and truncation;",
			sent_cnt);
		$display("checked %0d results, %0d string closes and %0d parse errors among them.",
			result_cnt, close_cnt, err_cnt);
		if (fail_cnt == 0 && expected_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timed out with %0d results still pending.", expected_q.size());
		$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
design/jsud_pkg.sv
design/jsud_if.sv
design/jsud_decoder.sv
design/jsud_serializer.sv
design/json_string_unescape_decoder.sv
bench/tb.sv
